// ===== rtl/core/sarg_pkg.sv =====
// shared constants, control word types and microprogram for the servo angle ramp generator
package sarg_pkg;

  // field widths
  localparam int PULSE_BITS = 12;
  localparam int ANGLE_BITS = 9;
  localparam int CHAN_BITS  = 4;
  localparam int STEP_BITS  = 5;
  localparam int CFG_IDX_BITS = 2;
  localparam int DIV_CNT_BITS = $clog2(ANGLE_BITS + 1);

  // angle limits and schedule thresholds
  localparam logic [ANGLE_BITS-1:0] ANGLE_MAX   = ANGLE_BITS'(270);
  localparam logic [ANGLE_BITS-1:0] SMALL_MOVE  = ANGLE_BITS'(10);
  localparam logic [ANGLE_BITS-1:0] NORM_SPLIT  = ANGLE_BITS'(50);
  localparam logic [ANGLE_BITS-1:0] FAST_SPLIT  = ANGLE_BITS'(120);
  localparam logic [STEP_BITS-1:0]  STEPS_NORM_LONG  = STEP_BITS'(30);
  localparam logic [STEP_BITS-1:0]  STEPS_NORM_SHORT = STEP_BITS'(20);
  localparam logic [STEP_BITS-1:0]  STEPS_FAST_LONG  = STEP_BITS'(25);
  localparam logic [STEP_BITS-1:0]  STEPS_FAST_SHORT = STEP_BITS'(15);

  // reset values of the configuration registers
  localparam logic [PULSE_BITS-1:0] PULSE_MIN_RST = PULSE_BITS'(150);
  localparam logic [PULSE_BITS-1:0] PULSE_MAX_RST = PULSE_BITS'(600);
  localparam logic [CHAN_BITS-1:0]  CHANNEL_RST   = CHAN_BITS'(0);

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_PULSE_MIN = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_PULSE_MAX = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_CHANNEL   = CFG_IDX_BITS'(2);

  // divide by 270 through a reciprocal: the error term stays below 2^shift for every product
  localparam int PROD_BITS   = ANGLE_BITS + PULSE_BITS;
  localparam int RECIP_SHIFT = PROD_BITS + 9;
  localparam int RECIP_BITS  = PROD_BITS + 1;
  localparam int BIG_BITS    = PROD_BITS + RECIP_BITS;
  localparam logic [RECIP_BITS-1:0] RECIP =
    RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd269) / 64'd270);

  // datapath operations
  localparam int OP_BITS = 3;
  localparam logic [OP_BITS-1:0] OP_NOP     = 3'd0;
  localparam logic [OP_BITS-1:0] OP_LOAD    = 3'd1;
  localparam logic [OP_BITS-1:0] OP_DIVSTEP = 3'd2;
  localparam logic [OP_BITS-1:0] OP_DIVFIX  = 3'd3;
  localparam logic [OP_BITS-1:0] OP_ANGLE   = 3'd4;
  localparam logic [OP_BITS-1:0] OP_MUL1    = 3'd5;
  localparam logic [OP_BITS-1:0] OP_MUL2    = 3'd6;
  localparam logic [OP_BITS-1:0] OP_EMIT    = 3'd7;

  // branch conditions: jump when true, else fall through
  localparam int CND_BITS = 3;
  localparam logic [CND_BITS-1:0] CND_NEXT     = 3'd0;
  localparam logic [CND_BITS-1:0] CND_JUMP     = 3'd1;
  localparam logic [CND_BITS-1:0] CND_WAIT_IN  = 3'd2;
  localparam logic [CND_BITS-1:0] CND_SINGLE   = 3'd3;
  localparam logic [CND_BITS-1:0] CND_DIV      = 3'd4;
  localparam logic [CND_BITS-1:0] CND_WAIT_OUT = 3'd5;
  localparam logic [CND_BITS-1:0] CND_LAST     = 3'd6;

  // program addresses
  localparam int PC_BITS = 4;
  localparam logic [PC_BITS-1:0] PC_IDLE   = 4'd0;
  localparam logic [PC_BITS-1:0] PC_BRANCH = 4'd1;
  localparam logic [PC_BITS-1:0] PC_DIV    = 4'd2;
  localparam logic [PC_BITS-1:0] PC_FIX    = 4'd3;
  localparam logic [PC_BITS-1:0] PC_STEP   = 4'd4;
  localparam logic [PC_BITS-1:0] PC_MAP    = 4'd5;
  localparam logic [PC_BITS-1:0] PC_SCALE  = 4'd6;
  localparam logic [PC_BITS-1:0] PC_EMIT   = 4'd7;
  localparam logic [PC_BITS-1:0] PC_TEST   = 4'd8;
  localparam logic [PC_BITS-1:0] PC_LOOP   = 4'd9;

  typedef struct packed {
    logic [OP_BITS-1:0]  op;
    logic [CND_BITS-1:0] cnd;
    logic [PC_BITS-1:0]  jmp;
  } sarg_ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic single;
    logic div_last;
    logic out_busy;
    logic last;
  } sarg_sts_t;

  // microprogram rom
  function automatic sarg_ctrl_t ucode(input logic [PC_BITS-1:0] pc);
    sarg_ctrl_t w;
    unique case (pc)
      PC_IDLE:   w = '{op: OP_LOAD,    cnd: CND_WAIT_IN,  jmp: PC_IDLE};
      PC_BRANCH: w = '{op: OP_NOP,     cnd: CND_SINGLE,   jmp: PC_MAP};
      PC_DIV:    w = '{op: OP_DIVSTEP, cnd: CND_DIV,      jmp: PC_DIV};
      PC_FIX:    w = '{op: OP_DIVFIX,  cnd: CND_NEXT,     jmp: PC_IDLE};
      PC_STEP:   w = '{op: OP_ANGLE,   cnd: CND_NEXT,     jmp: PC_IDLE};
      PC_MAP:    w = '{op: OP_MUL1,    cnd: CND_NEXT,     jmp: PC_IDLE};
      PC_SCALE:  w = '{op: OP_MUL2,    cnd: CND_NEXT,     jmp: PC_IDLE};
      PC_EMIT:   w = '{op: OP_EMIT,    cnd: CND_WAIT_OUT, jmp: PC_EMIT};
      PC_TEST:   w = '{op: OP_NOP,     cnd: CND_LAST,     jmp: PC_IDLE};
      PC_LOOP:   w = '{op: OP_NOP,     cnd: CND_JUMP,     jmp: PC_STEP};
      default:   w = '{op: OP_NOP,     cnd: CND_JUMP,     jmp: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/sarg_seq.sv =====
// microprogram sequencer: step counter, control rom and branch logic
module sarg_seq
  import sarg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  sarg_sts_t  sts,
  output sarg_ctrl_t ctrl
);

  logic [PC_BITS-1:0] pc_r;
  logic [PC_BITS-1:0] pc_nxt;
  logic               take;

  assign ctrl = ucode(pc_r);

  // branch condition select
  always_comb begin
    unique case (ctrl.cnd)
      CND_NEXT:     take = 1'b0;
      CND_JUMP:     take = 1'b1;
      CND_WAIT_IN:  take = !sts.in_valid;
      CND_SINGLE:   take = sts.single;
      CND_DIV:      take = !sts.div_last;
      CND_WAIT_OUT: take = sts.out_busy;
      CND_LAST:     take = sts.last;
      default:      take = 1'b1;
    endcase
    pc_nxt = take ? ctrl.jmp : pc_r + PC_BITS'(1);
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== rtl/core/servo_angle_ramp_generator.sv =====
// Servo angle ramp generator top level: datapath, configuration registers and result register.
// Each accepted transaction names a target angle (saturated to 270) and a speed mode. When the
// current angle is not yet known, or the move is under 10 degrees, one pulse for the target comes
// out. Otherwise a linear ramp of N pulses comes out, N being 30/20 (normal) or 25/15 (fast),
// built from a 9-pass restoring divide of the move by N and a six-step microprogram per pulse
// (angle update, angle times span, reciprocal multiply for the divide by 270, emit, two branches).
// The final pulse of every move carries out_last. Output back pressure stalls the microprogram at
// the emit step; once the last pulse enters the result register, the test step returns to the
// load step and the next transaction can be taken, whether or not that pulse has been delivered.
// Configuration is written through the cfg port, which is always ready, and must only change
// while idle.
module servo_angle_ramp_generator
  import sarg_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [ANGLE_BITS-1:0]   in_target_angle,
  input  logic                    in_fast_mode,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [PULSE_BITS-1:0]   out_pulse,
  output logic [CHAN_BITS-1:0]    out_channel,
  output logic                    out_last,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [PULSE_BITS-1:0]   cfg_data
);

  sarg_ctrl_t ctrl;
  sarg_sts_t  sts;

  // configuration
  logic [PULSE_BITS-1:0] pulse_min_r;
  logic [PULSE_BITS-1:0] pulse_max_r;
  logic [CHAN_BITS-1:0]  channel_r;

  // move state
  logic [ANGLE_BITS-1:0] cur_r;
  logic                  known_r;

  // per-move working registers
  logic [ANGLE_BITS-1:0]   q_r;
  logic [STEP_BITS-1:0]    r_r;
  logic [STEP_BITS-1:0]    i_r;
  logic [STEP_BITS-1:0]    steps_r;
  logic                    single_r;
  logic                    last_r;
  logic                    neg_r;
  logic [ANGLE_BITS-1:0]   dq_r;
  logic [STEP_BITS-1:0]    dr_r;
  logic [ANGLE_BITS-1:0]   dv_quo_r;
  logic [STEP_BITS-1:0]    dv_rem_r;
  logic [DIV_CNT_BITS-1:0] dv_cnt_r;
  logic [PULSE_BITS-1:0]   span_r;
  logic                    fall_r;
  logic [PROD_BITS-1:0]    prod_r;
  logic [PULSE_BITS-1:0]   quo_r;

  // result register
  logic                  out_valid_r;
  logic [PULSE_BITS-1:0] out_pulse_r;
  logic [CHAN_BITS-1:0]  out_channel_r;
  logic                  out_last_r;

  logic                  load_en;
  logic                  emit_en;
  logic                  out_busy;
  logic [ANGLE_BITS-1:0] tgt;
  logic [ANGLE_BITS-1:0] diff;
  logic                  single;
  logic [STEP_BITS-1:0]  steps;
  logic [STEP_BITS:0]    trial;
  logic                  trial_ge;
  logic [STEP_BITS:0]    rsum;
  logic                  rwrap;
  logic [BIG_BITS-1:0]   big;

  sarg_seq u_seq (
    .clk  (clk),
    .rst_n(rst_n),
    .sts  (sts),
    .ctrl (ctrl)
  );

  assign out_busy = out_valid_r && !out_ready;
  assign load_en  = (ctrl.op == OP_LOAD) && in_valid;
  assign emit_en  = (ctrl.op == OP_EMIT) && !out_busy;
  assign in_ready = (ctrl.op == OP_LOAD);
  assign cfg_ready = 1'b1;

  assign sts.in_valid = in_valid;
  assign sts.single   = single_r;
  assign sts.div_last = (dv_cnt_r == DIV_CNT_BITS'(1));
  assign sts.out_busy = out_busy;
  assign sts.last     = last_r;

  assign out_valid   = out_valid_r;
  assign out_pulse   = out_pulse_r;
  assign out_channel = out_channel_r;
  assign out_last    = out_last_r;

  // move classification at acceptance
  always_comb begin
    tgt    = (in_target_angle > ANGLE_MAX) ? ANGLE_MAX : in_target_angle;
    diff   = (tgt > cur_r) ? tgt - cur_r : cur_r - tgt;
    single = !known_r || (diff < SMALL_MOVE);
    if (in_fast_mode) begin
      steps = (diff > FAST_SPLIT) ? STEPS_FAST_LONG : STEPS_FAST_SHORT;
    end else begin
      steps = (diff > NORM_SPLIT) ? STEPS_NORM_LONG : STEPS_NORM_SHORT;
    end
  end

  // one restoring divide pass, the remainder step of the angle update, and the reciprocal product
  always_comb begin
    trial    = {dv_rem_r, dv_quo_r[ANGLE_BITS-1]};
    trial_ge = (trial >= {1'b0, steps_r});
    rsum     = {1'b0, r_r} + {1'b0, dr_r};
    rwrap    = (rsum >= {1'b0, steps_r});
    big      = BIG_BITS'(prod_r) * BIG_BITS'(RECIP);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_min_r <= PULSE_MIN_RST;
      pulse_max_r <= PULSE_MAX_RST;
      channel_r   <= CHANNEL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PULSE_MIN: pulse_min_r <= cfg_data;
        REG_PULSE_MAX: pulse_max_r <= cfg_data;
        REG_CHANNEL:   channel_r   <= cfg_data[CHAN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // current angle tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r   <= '0;
      known_r <= 1'b0;
    end else if (load_en) begin
      cur_r   <= tgt;
      known_r <= 1'b1;
    end
  end

  // datapath driven by the control word
  always_ff @(posedge clk) begin
    if (load_en) begin
      q_r      <= single ? tgt : cur_r;
      r_r      <= '0;
      i_r      <= '0;
      steps_r  <= steps;
      single_r <= single;
      last_r   <= single;
      neg_r    <= (tgt < cur_r);
      dv_quo_r <= diff;
      dv_rem_r <= '0;
      dv_cnt_r <= DIV_CNT_BITS'(ANGLE_BITS);
      fall_r   <= (pulse_max_r < pulse_min_r);
      span_r   <= (pulse_max_r >= pulse_min_r) ? pulse_max_r - pulse_min_r
                                               : pulse_min_r - pulse_max_r;
    end
    if (ctrl.op == OP_DIVSTEP) begin
      dv_rem_r <= trial_ge ? STEP_BITS'(trial - {1'b0, steps_r}) : trial[STEP_BITS-1:0];
      dv_quo_r <= {dv_quo_r[ANGLE_BITS-2:0], trial_ge};
      dv_cnt_r <= dv_cnt_r - DIV_CNT_BITS'(1);
    end
    // floor division of the signed move by the step count
    if (ctrl.op == OP_DIVFIX) begin
      if (!neg_r) begin
        dq_r <= dv_quo_r;
        dr_r <= dv_rem_r;
      end else if (dv_rem_r == '0) begin
        dq_r <= ~dv_quo_r + ANGLE_BITS'(1);
        dr_r <= '0;
      end else begin
        dq_r <= ~dv_quo_r;
        dr_r <= steps_r - dv_rem_r;
      end
    end
    // next ramp angle kept as quotient and remainder over the step count
    if (ctrl.op == OP_ANGLE) begin
      q_r    <= q_r + dq_r + ANGLE_BITS'(rwrap);
      r_r    <= rwrap ? STEP_BITS'(rsum - {1'b0, steps_r}) : rsum[STEP_BITS-1:0];
      i_r    <= i_r + STEP_BITS'(1);
      last_r <= ((i_r + STEP_BITS'(1)) == steps_r);
    end
    if (ctrl.op == OP_MUL1) begin
      prod_r <= PROD_BITS'(q_r) * PROD_BITS'(span_r);
    end
    if (ctrl.op == OP_MUL2) begin
      quo_r <= big[RECIP_SHIFT +: PULSE_BITS];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_en) begin
      out_pulse_r   <= fall_r ? pulse_min_r - quo_r : pulse_min_r + quo_r;
      out_channel_r <= channel_r;
      out_last_r    <= last_r;
    end
  end

endmodule

// ===== rtl/core/sarg_chk.sv =====
// port-level checker for the servo angle ramp generator, bound to the top level
module sarg_chk
  import sarg_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [PULSE_BITS-1:0]   out_pulse,
  input logic [CHAN_BITS-1:0]    out_channel,
  input logic                    out_last
);

  logic [1:0] pend_r;
  logic [1:0] pend_nxt;
  logic       in_acc;
  logic       last_acc;

  assign in_acc   = in_valid && in_ready;
  assign last_acc = out_valid && out_ready && out_last;
  assign pend_nxt = pend_r + 2'(in_acc) - 2'(last_acc);

  // moves accepted whose last pulse is not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pulse) && $stable(out_channel)
      && $stable(out_last))
    else $error("result changed while stalled");

  // a new move is never taken in the cycle after one was taken
  a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("back to back input transactions");

  // no pulse without an open move
  a_out_owner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("pulse with no move in progress");

  // at most one earlier move may still have its last pulse pending
  a_in_depth: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> pend_r <= 2'd1)
    else $error("input taken while a ramp is still running");

endmodule

bind servo_angle_ramp_generator sarg_chk u_sarg_chk (.*);

// ===== test/testbench.sv =====
// self-checking testbench for the servo angle ramp generator
module testbench;
  import sarg_pkg::*;

  // one expected pwm pulse transaction
  typedef struct packed {
    logic [PULSE_BITS-1:0] pulse;
    logic [CHAN_BITS-1:0]  chan;
    logic                  last;
  } pulse_rec_t;

  // ramp predictor and store of pulses still owed by the block
  class ramp_scoreboard;
    logic [PULSE_BITS-1:0] pulse_min;
    logic [PULSE_BITS-1:0] pulse_max;
    logic [CHAN_BITS-1:0]  channel;
    int unsigned           cur_angle;
    bit                    angle_known;
    pulse_rec_t            owed_pulses[$];
    int                    mismatch_count;

    function new();
      pulse_min      = PULSE_MIN_RST;
      pulse_max      = PULSE_MAX_RST;
      channel        = CHANNEL_RST;
      cur_angle      = 0;
      angle_known    = 0;
      mismatch_count = 0;
    endfunction

    task report_mismatch(string msg);
      mismatch_count++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [PULSE_BITS-1:0] data);
      case (idx)
        REG_PULSE_MIN: pulse_min = data;
        REG_PULSE_MAX: pulse_max = data;
        REG_CHANNEL:   channel = data[CHAN_BITS-1:0];
        default: ;
      endcase
    endfunction

    // linear map from degrees to pwm off count, truncating toward zero
    function logic [PULSE_BITS-1:0] angle_to_count(int unsigned ang);
      int lo;
      int hi;
      int q;
      lo = int'(pulse_min);
      hi = int'(pulse_max);
      if (hi >= lo)
        q = (int'(ang) * (hi - lo)) / int'(ANGLE_MAX);
      else
        q = -((int'(ang) * (lo - hi)) / int'(ANGLE_MAX));
      return PULSE_BITS'(lo + q);
    endfunction

    function void owe_pulse(int unsigned ang, bit is_last);
      pulse_rec_t rec;
      rec.pulse = angle_to_count(ang);
      rec.chan  = channel;
      rec.last  = is_last;
      owed_pulses.push_back(rec);
    endfunction

    // work out every pulse that one accepted move causes
    function void note_move(logic [ANGLE_BITS-1:0] target_in, logic fast);
      int unsigned tgt;
      int unsigned start;
      int unsigned diff;
      int unsigned steps;
      tgt = target_in;
      if (tgt > ANGLE_MAX)
        tgt = ANGLE_MAX;
      start = cur_angle;
      diff = (tgt > start) ? tgt - start : start - tgt;
      if (!angle_known || diff < SMALL_MOVE) begin
        owe_pulse(tgt, 1'b1);
      end else begin
        if (fast)
          steps = (diff > FAST_SPLIT) ? STEPS_FAST_LONG : STEPS_FAST_SHORT;
        else
          steps = (diff > NORM_SPLIT) ? STEPS_NORM_LONG : STEPS_NORM_SHORT;
        for (int unsigned i = 1; i <= steps; i++)
          owe_pulse((start * (steps - i) + tgt * i) / steps, i == steps);
      end
      cur_angle   = tgt;
      angle_known = 1'b1;
    endfunction

    task check_pulse(logic [PULSE_BITS-1:0] pulse, logic [CHAN_BITS-1:0] chan, logic last);
      pulse_rec_t want;
      if (owed_pulses.size() == 0) begin
        report_mismatch($sformatf("unexpected pulse %0d chan %0d last %0b", pulse, chan, last));
        return;
      end
      want = owed_pulses.pop_front();
      if (pulse !== want.pulse)
        report_mismatch($sformatf("pulse %0d, want %0d", pulse, want.pulse));
      if (chan !== want.chan)
        report_mismatch($sformatf("channel %0d, want %0d", chan, want.chan));
      if (last !== want.last)
        report_mismatch($sformatf("last %0b, want %0b", last, want.last));
    endtask

    function int owed();
      return owed_pulses.size();
    endfunction
  endclass

  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 400;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [ANGLE_BITS-1:0]   in_target_angle;
  logic                    in_fast_mode;
  logic                    out_valid;
  logic                    out_ready;
  logic [PULSE_BITS-1:0]   out_pulse;
  logic [CHAN_BITS-1:0]    out_channel;
  logic                    out_last;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [PULSE_BITS-1:0]   cfg_data;

  ramp_scoreboard sb = new();
  bit          calm = 1'b0;
  bit          hold_off_req = 1'b0;
  int unsigned last_angle = 0;

  servo_angle_ramp_generator dut (.*);

  always #10 clk = ~clk;

  // watch the three channels
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready)
      sb.set_reg(cfg_index, cfg_data);
    if (rst_n && in_valid && in_ready)
      sb.note_move(in_target_angle, in_fast_mode);
    if (rst_n && out_valid && out_ready)
      sb.check_pulse(out_pulse, out_channel, out_last);
  end

  // result side: random stall bursts, long runs, one long hold-off on request
  initial begin : receiver
    int held;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(posedge clk);
          held++;
        end
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 7) == 0)
          repeat (60) @(posedge clk);
        else
          repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // offer one move and wait for its transaction
  task send_move(logic [ANGLE_BITS-1:0] tgt, logic fast);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_target_angle <= tgt;
    in_fast_mode    <= fast;
    do @(posedge clk); while (!in_ready);
    last_angle = (tgt > ANGLE_MAX) ? ANGLE_MAX : tgt;
  endtask

  task write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [PULSE_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task write_config(logic [PULSE_BITS-1:0] lo, logic [PULSE_BITS-1:0] hi,
                    logic [PULSE_BITS-1:0] chan);
    write_reg(REG_PULSE_MIN, lo);
    write_reg(REG_PULSE_MAX, hi);
    write_reg(REG_CHANNEL, chan);
  endtask

  // stop offering and let every owed pulse come out before touching registers;
  // the scoreboard notes the move accepted last before the owed count is read
  task drain(int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.owed() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // mostly legal angles, some small moves, some above the saturation point
  function automatic logic [ANGLE_BITS-1:0] pick_target();
    int unsigned lo;
    int unsigned hi;
    lo = (last_angle > 12) ? last_angle - 12 : 0;
    hi = (last_angle + 12 > ANGLE_MAX) ? ANGLE_MAX : last_angle + 12;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return ANGLE_BITS'($urandom_range(0, 270));
      6:                return ANGLE_BITS'($urandom_range(271, 511));
      7:                return ANGLE_BITS'($urandom_range(lo, hi));
      default:          return ANGLE_BITS'($urandom_range(0, 511));
    endcase
  endfunction

  initial begin : stimulus
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_target_angle <= '0;
    in_fast_mode    <= 1'b0;
    cfg_valid       <= 1'b0;
    cfg_index       <= REG_PULSE_MIN;
    cfg_data        <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed moves at reset config: unknown angle, saturation, schedule edges
    send_move(9'd0,   1'b0);
    send_move(9'd270, 1'b0);
    send_move(9'd0,   1'b1);
    send_move(9'd511, 1'b0);
    send_move(9'd300, 1'b1);
    send_move(9'd261, 1'b0);
    send_move(9'd251, 1'b0);
    send_move(9'd200, 1'b1);
    send_move(9'd149, 1'b0);
    send_move(9'd99,  1'b0);
    send_move(9'd219, 1'b1);
    send_move(9'd98,  1'b1);
    send_move(9'd256, 1'b0);
    send_move(9'd511, 1'b1);
    send_move(9'd0,   1'b1);
    drain(SETTLE_CYCLES);

    // falling map at the register extremes
    write_config(12'hFFF, 12'h000, 12'hFFF);
    send_move(9'd270, 1'b0);
    send_move(9'd135, 1'b1);
    send_move(9'd0,   1'b0);
    drain(SETTLE_CYCLES);

    // full rising span, then a flat map
    write_config(12'h000, 12'hFFF, 12'h000);
    send_move(9'd270, 1'b1);
    send_move(9'd1,   1'b0);
    drain(SETTLE_CYCLES);
    write_config(12'd2048, 12'd2048, 12'd5);
    send_move(9'd181, 1'b1);
    send_move(9'd179, 1'b0);
    drain(SETTLE_CYCLES);

    // random phases with random registers; one long output hold, quiet last phase
    for (int phase = 0; phase < 6; phase++) begin
      write_config(PULSE_BITS'($urandom_range(0, 4095)), PULSE_BITS'($urandom_range(0, 4095)),
                   PULSE_BITS'($urandom_range(0, 4095)));
      if (phase == 2)
        hold_off_req = 1'b1;
      if (phase == 5)
        calm = 1'b1;
      for (int k = 0; k < 75; k++)
        send_move(pick_target(), 1'($urandom_range(0, 1)));
      drain(SETTLE_CYCLES);
    end

    drain(200);
    if (sb.mismatch_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin : watchdog
    #30000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/sarg_pkg.sv
rtl/core/sarg_seq.sv
rtl/core/servo_angle_ramp_generator.sv
rtl/core/sarg_chk.sv
test/testbench.sv
